// ----- rtl/lbm_pkg.sv -----
// shared types, constants and helper functions for the d3q19 streaming unit
// no dependencies; used by every module of the block
package lbm_pkg;

  // default lattice limits and fixed field widths
  localparam int MAX_X_DEF          = 16;
  localparam int MAX_Y_DEF          = 16;
  localparam int MAX_Z_DEF          = 16;
  localparam int NUM_COMPONENTS_DEF = 2;
  localparam int DIRECTIONS         = 19;

  localparam int SIZE_W  = 5;
  localparam int COORD_W = 4;
  localparam int DIR_W   = 5;
  localparam int WORD_W  = 64;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // result buffer
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_W     = WORD_W + 1;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // d3q19 direction codes
  localparam logic [DIR_W-1:0] DIR_C  = 5'd0;
  localparam logic [DIR_W-1:0] DIR_E  = 5'd1;
  localparam logic [DIR_W-1:0] DIR_W_ = 5'd2;
  localparam logic [DIR_W-1:0] DIR_N  = 5'd3;
  localparam logic [DIR_W-1:0] DIR_S  = 5'd4;
  localparam logic [DIR_W-1:0] DIR_NW = 5'd5;
  localparam logic [DIR_W-1:0] DIR_NE = 5'd6;
  localparam logic [DIR_W-1:0] DIR_SW = 5'd7;
  localparam logic [DIR_W-1:0] DIR_SE = 5'd8;
  localparam logic [DIR_W-1:0] DIR_T  = 5'd9;
  localparam logic [DIR_W-1:0] DIR_TW = 5'd10;
  localparam logic [DIR_W-1:0] DIR_TE = 5'd11;
  localparam logic [DIR_W-1:0] DIR_TN = 5'd12;
  localparam logic [DIR_W-1:0] DIR_TS = 5'd13;
  localparam logic [DIR_W-1:0] DIR_B  = 5'd14;
  localparam logic [DIR_W-1:0] DIR_BW = 5'd15;
  localparam logic [DIR_W-1:0] DIR_BE = 5'd16;
  localparam logic [DIR_W-1:0] DIR_BN = 5'd17;
  localparam logic [DIR_W-1:0] DIR_BS = 5'd18;

  // velocity component codes
  localparam logic signed [1:0] V_P = 2'sb01;
  localparam logic signed [1:0] V_0 = 2'sb00;
  localparam logic signed [1:0] V_M = 2'sb11;

  typedef struct packed {
    logic signed [1:0] x;
    logic signed [1:0] y;
    logic signed [1:0] z;
  } lbm_vel_t;

  // access command travelling down the pipeline
  typedef struct packed {
    logic valid;
    logic wr;
    logic rd;
    logic range_error;
  } lbm_ctrl_t;

  // lattice velocity of each direction
  function automatic lbm_vel_t dir_vel(logic [DIR_W-1:0] d);
    lbm_vel_t v;
    case (d)
      DIR_C:   v = '{V_0, V_0, V_0};
      DIR_E:   v = '{V_P, V_0, V_0};
      DIR_W_:  v = '{V_M, V_0, V_0};
      DIR_N:   v = '{V_0, V_P, V_0};
      DIR_S:   v = '{V_0, V_M, V_0};
      DIR_NW:  v = '{V_M, V_P, V_0};
      DIR_NE:  v = '{V_P, V_P, V_0};
      DIR_SW:  v = '{V_M, V_M, V_0};
      DIR_SE:  v = '{V_P, V_M, V_0};
      DIR_T:   v = '{V_0, V_0, V_P};
      DIR_TW:  v = '{V_M, V_0, V_P};
      DIR_TE:  v = '{V_P, V_0, V_P};
      DIR_TN:  v = '{V_0, V_P, V_P};
      DIR_TS:  v = '{V_0, V_M, V_P};
      DIR_B:   v = '{V_0, V_0, V_M};
      DIR_BW:  v = '{V_M, V_0, V_M};
      DIR_BE:  v = '{V_P, V_0, V_M};
      DIR_BN:  v = '{V_0, V_P, V_M};
      DIR_BS:  v = '{V_0, V_M, V_M};
      default: v = '{V_0, V_0, V_0};
    endcase
    return v;
  endfunction

  // one periodic step along an axis of n nodes, pos below n
  function automatic logic [SIZE_W-1:0] wrap_step(logic [SIZE_W-1:0] pos,
                                                  logic signed [1:0] v,
                                                  logic [SIZE_W-1:0] n);
    logic [SIZE_W:0] inc;
    logic [SIZE_W-1:0] res;
    inc = {1'b0, pos} + (SIZE_W+1)'(1);
    if (v == V_P) begin
      res = (inc >= {1'b0, n}) ? '0 : inc[SIZE_W-1:0];
    end else if (v == V_M) begin
      res = (pos == '0) ? n - SIZE_W'(1) : pos - SIZE_W'(1);
    end else begin
      res = pos;
    end
    return res;
  endfunction

  // size register saturated at the axis limit
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] r, int lim);
    logic [SIZE_W-1:0] res;
    res = (int'(r) > lim) ? SIZE_W'(lim) : r;
    return res;
  endfunction

endpackage

// ----- rtl/lbm_addr_gen.sv -----
// coordinate check, periodic neighbour step and linear store address
// depends on lbm_pkg
module lbm_addr_gen #(
  parameter int MAX_X          = lbm_pkg::MAX_X_DEF,
  parameter int MAX_Y          = lbm_pkg::MAX_Y_DEF,
  parameter int MAX_Z          = lbm_pkg::MAX_Z_DEF,
  parameter int NUM_COMPONENTS = lbm_pkg::NUM_COMPONENTS_DEF,
  parameter int AW             = 18
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              opcode,
  input  logic                              component,
  input  logic [lbm_pkg::COORD_W-1:0]       node_x,
  input  logic [lbm_pkg::COORD_W-1:0]       node_y,
  input  logic [lbm_pkg::COORD_W-1:0]       node_z,
  input  logic [lbm_pkg::DIR_W-1:0]         direction,
  input  logic [lbm_pkg::WORD_W-1:0]        value,
  input  logic [lbm_pkg::SIZE_W-1:0]        size_x,
  input  logic [lbm_pkg::SIZE_W-1:0]        size_y,
  input  logic [lbm_pkg::SIZE_W-1:0]        size_z,
  output lbm_pkg::lbm_ctrl_t                acc_ctrl,
  output logic [AW-1:0]                     acc_addr,
  output logic [lbm_pkg::WORD_W-1:0]        acc_data
);

  localparam int PW = $clog2(NUM_COMPONENTS * MAX_Z * MAX_Y);

  logic [lbm_pkg::SIZE_W-1:0] nx, ny, nz;
  logic [lbm_pkg::SIZE_W-1:0] src_x, src_y, src_z;
  logic [lbm_pkg::SIZE_W-1:0] cx, cy, cz;
  lbm_pkg::lbm_vel_t          vel;
  logic                       range_err;
  logic                       sel_ok;
  lbm_pkg::lbm_ctrl_t         ctrl_in;

  // stage a registers
  lbm_pkg::lbm_ctrl_t         a_ctrl;
  logic [lbm_pkg::SIZE_W-1:0] a_x, a_y, a_z;
  logic                       a_comp;
  logic [lbm_pkg::DIR_W-1:0]  a_dir;
  logic [lbm_pkg::WORD_W-1:0] a_data;

  // stage b registers
  lbm_pkg::lbm_ctrl_t         b_ctrl;
  logic [PW-1:0]              b_part;
  logic [lbm_pkg::SIZE_W-1:0] b_x;
  logic [lbm_pkg::DIR_W-1:0]  b_dir;
  logic [lbm_pkg::WORD_W-1:0] b_data;

  // range check and neighbour node
  always_comb begin
    nx    = lbm_pkg::clamp_size(size_x, MAX_X);
    ny    = lbm_pkg::clamp_size(size_y, MAX_Y);
    nz    = lbm_pkg::clamp_size(size_z, MAX_Z);
    src_x = {1'b0, node_x};
    src_y = {1'b0, node_y};
    src_z = {1'b0, node_z};
    range_err = (src_x >= nx) || (src_y >= ny) || (src_z >= nz);
    sel_ok    = (direction < lbm_pkg::DIR_W'(lbm_pkg::DIRECTIONS)) &&
                (int'(component) < NUM_COMPONENTS);
    vel = lbm_pkg::dir_vel(direction);
    if (opcode == lbm_pkg::OP_READ) begin
      cx = src_x;
      cy = src_y;
      cz = src_z;
    end else begin
      cx = lbm_pkg::wrap_step(src_x, vel.x, nx);
      cy = lbm_pkg::wrap_step(src_y, vel.y, ny);
      cz = lbm_pkg::wrap_step(src_z, vel.z, nz);
    end
    ctrl_in.valid       = in_valid;
    ctrl_in.wr          = in_valid && !range_err && sel_ok && (opcode == lbm_pkg::OP_WRITE);
    ctrl_in.rd          = in_valid && !range_err && sel_ok && (opcode == lbm_pkg::OP_READ);
    ctrl_in.range_error = range_err;
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctrl   <= '0;
      b_ctrl   <= '0;
      acc_ctrl <= '0;
    end else begin
      a_ctrl   <= ctrl_in;
      b_ctrl   <= a_ctrl;
      acc_ctrl <= b_ctrl;
    end
  end

  // payload pipeline: node coordinates folded into a linear address
  always_ff @(posedge clk) begin
    a_x    <= cx;
    a_y    <= cy;
    a_z    <= cz;
    a_comp <= component;
    a_dir  <= direction;
    a_data <= value;

    b_part <= PW'((AW'(a_comp) * AW'(MAX_Z) + AW'(a_z)) * AW'(MAX_Y) + AW'(a_y));
    b_x    <= a_x;
    b_dir  <= a_dir;
    b_data <= a_data;

    acc_addr <= AW'((AW'(b_part) * AW'(MAX_X) + AW'(b_x)) * AW'(lbm_pkg::DIRECTIONS)
                    + AW'(b_dir));
    acc_data <= b_data;
  end

endmodule

// ----- rtl/lbm_store.sv -----
// post-stream word store: single-port synchronous ram, one access a cycle
// depends on lbm_pkg
module lbm_store #(
  parameter int DEPTH = 155648,
  parameter int AW    = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lbm_pkg::lbm_ctrl_t         acc_ctrl,
  input  logic [AW-1:0]              acc_addr,
  input  logic [lbm_pkg::WORD_W-1:0] acc_data,
  output lbm_pkg::lbm_ctrl_t         rd_ctrl,
  output logic [lbm_pkg::WORD_W-1:0] rd_data
);

  logic [lbm_pkg::WORD_W-1:0] mem [DEPTH];

  // write or registered read
  always_ff @(posedge clk) begin
    if (acc_ctrl.wr) begin
      mem[acc_addr] <= acc_data;
    end
    if (acc_ctrl.rd) begin
      rd_data <= mem[acc_addr];
    end
  end

  // command aligned with read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctrl <= '0;
    end else begin
      rd_ctrl <= acc_ctrl;
    end
  end

endmodule

// ----- rtl/lbm_out_fifo.sv -----
// result buffer between the store pipeline and the output beat
// depends on lbm_pkg
module lbm_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [lbm_pkg::FIFO_W-1:0] push_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lbm_pkg::FIFO_W-1:0] out_data
);

  logic [lbm_pkg::FIFO_W-1:0]   buf_mem [lbm_pkg::FIFO_DEPTH];
  logic [lbm_pkg::PTR_W-1:0]    wr_ptr;
  logic [lbm_pkg::PTR_W-1:0]    rd_ptr;
  logic [lbm_pkg::CREDIT_W-1:0] count;
  logic                         pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = buf_mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lbm_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lbm_pkg::PTR_W'(1);
      end
      count <= count + lbm_pkg::CREDIT_W'(push) - lbm_pkg::CREDIT_W'(pop);
    end
  end

`ifndef SYNTH
  // never overrun
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < lbm_pkg::CREDIT_W'(lbm_pkg::FIFO_DEPTH))
    else $error("result buffer overrun");
`endif

endmodule

// ----- rtl/lbm_d3q19_periodic_stream_unit.sv -----
// top level of the d3q19 periodic streaming unit
// depends on lbm_pkg, lbm_addr_gen, lbm_store, lbm_out_fifo
//
// Takes one beat per cycle on the slave side while s_tready is high and returns exactly one
// result beat per item, in order: a write item streams its 64-bit word to the neighbour
// node along its direction, with periodic wrap at the configured sizes, and answers zero; a
// read item answers the stored word, or zero if rejected. The sustained rate is one item
// per cycle while results are taken, set by the single-port store ram. An accepted input beat
// passes three address stages, the registered ram read and the result buffer before its result
// is offered. An eight-beat result buffer lets input continue while results wait; s_tready
// drops only when eight items are accepted and not yet taken. The store needs no clearing
// after reset: a read of a word that was never written returns an unspecified value. The user
// must write size registers only while no item is in flight; the block does not enforce it.
module lbm_d3q19_periodic_stream_unit #(
  parameter int MAX_X          = lbm_pkg::MAX_X_DEF,
  parameter int MAX_Y          = lbm_pkg::MAX_Y_DEF,
  parameter int MAX_Z          = lbm_pkg::MAX_Z_DEF,
  parameter int NUM_COMPONENTS = lbm_pkg::NUM_COMPONENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [lbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbm_pkg::SIZE_W-1:0]    cfg_data,
  // input items
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [87:0]                   s_tdata,  // node_x, node_y, node_z, direction, value
  input  logic [1:0]                    s_tuser,  // opcode, component
  // result items
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [63:0]                   m_tdata,  // read_value
  output logic [0:0]                    m_tuser   // range_error
);

  localparam int DEPTH = NUM_COMPONENTS * MAX_Z * MAX_Y * MAX_X * lbm_pkg::DIRECTIONS;
  localparam int AW    = $clog2(DEPTH);

  logic [lbm_pkg::SIZE_W-1:0]   size_x, size_y, size_z;
  logic [lbm_pkg::CREDIT_W-1:0] credit;
  logic                         in_accept;
  logic                         out_pop;

  lbm_pkg::lbm_ctrl_t           acc_ctrl;
  logic [AW-1:0]                acc_addr;
  logic [lbm_pkg::WORD_W-1:0]   acc_data;
  lbm_pkg::lbm_ctrl_t           rd_ctrl;
  logic [lbm_pkg::WORD_W-1:0]   rd_data;
  logic [lbm_pkg::FIFO_W-1:0]   push_data;
  logic [lbm_pkg::FIFO_W-1:0]   out_data;

  assign s_tready  = credit < lbm_pkg::CREDIT_W'(lbm_pkg::FIFO_DEPTH);
  assign in_accept = s_tvalid && s_tready;
  assign out_pop   = m_tvalid && m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= lbm_pkg::SIZE_RESET;
      size_y <= lbm_pkg::SIZE_RESET;
      size_z <= lbm_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lbm_pkg::REG_SIZE_X: size_x <= cfg_data;
        lbm_pkg::REG_SIZE_Y: size_y <= cfg_data;
        lbm_pkg::REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // items accepted and not yet taken, bounded by the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + lbm_pkg::CREDIT_W'(in_accept) - lbm_pkg::CREDIT_W'(out_pop);
    end
  end

  lbm_addr_gen #(
    .MAX_X          (MAX_X),
    .MAX_Y          (MAX_Y),
    .MAX_Z          (MAX_Z),
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .AW             (AW)
  ) u_addr_gen (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_accept),
    .opcode    (s_tuser[0]),
    .component (s_tuser[1]),
    .node_x    (s_tdata[3:0]),
    .node_y    (s_tdata[7:4]),
    .node_z    (s_tdata[11:8]),
    .direction (s_tdata[16:12]),
    .value     (s_tdata[80:17]),
    .size_x    (size_x),
    .size_y    (size_y),
    .size_z    (size_z),
    .acc_ctrl  (acc_ctrl),
    .acc_addr  (acc_addr),
    .acc_data  (acc_data)
  );

  lbm_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .acc_ctrl (acc_ctrl),
    .acc_addr (acc_addr),
    .acc_data (acc_data),
    .rd_ctrl  (rd_ctrl),
    .rd_data  (rd_data)
  );

  // result word is zero unless the store was read
  assign push_data = {rd_ctrl.range_error, rd_ctrl.rd ? rd_data : lbm_pkg::WORD_W'(0)};

  lbm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rd_ctrl.valid),
    .push_data (push_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata    = out_data[lbm_pkg::WORD_W-1:0];
  assign m_tuser[0] = out_data[lbm_pkg::WORD_W];

`ifndef SYNTH
  // outstanding count stays within the buffer
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= lbm_pkg::CREDIT_W'(lbm_pkg::FIFO_DEPTH))
    else $error("outstanding item count beyond buffer depth");

  // a result beat always belongs to an accepted item
  a_out_has_credit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> credit != '0)
    else $error("result beat without an outstanding item");

  // one store access per command, never with a range fault
  a_single_access: assert property (@(posedge clk) disable iff (rst)
    (acc_ctrl.wr || acc_ctrl.rd) |-> acc_ctrl.valid && !(acc_ctrl.wr && acc_ctrl.rd)
                                     && !acc_ctrl.range_error)
    else $error("malformed store access");

  // every accepted item reaches the result buffer through the address stages and the store
  a_push_latency: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> ##4 rd_ctrl.valid)
    else $error("accepted item lost in pipeline");
`endif

endmodule
